// File: rtl/pdfue_pkg.sv
package pdfue_pkg;

  localparam int MAX_VARIATIONS = 1024;
  localparam int FRAC_BITS      = 16;
  localparam int QUEUE_DEPTH    = 2;
  localparam int PTR_W          = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);
  localparam int MUL_STEPS      = 6;
  localparam int STEP_W         = $clog2(MUL_STEPS);
  localparam int DIV_STEPS      = 96;
  localparam int ROOT_STEPS     = 32;
  localparam int SEQ_W          = $clog2(DIV_STEPS);

  // envelope modes; bit 1 set selects replica standard deviation
  localparam logic [1:0] MODE_SYM  = 2'd0;
  localparam logic [1:0] MODE_ASYM = 2'd1;

  // configuration register indexes
  localparam logic [1:0] REG_MODE       = 2'd0;
  localparam logic [1:0] REG_NUM_VAR    = 2'd1;
  localparam logic [1:0] REG_SCALE_ORIG = 2'd2;
  localparam logic [1:0] REG_SCALE_CEN  = 2'd3;

  typedef struct packed {
    logic [1:0]  envelope_mode;
    logic [10:0] num_variations;
    logic [23:0] scale_orig;
    logic [23:0] scale_cen;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] orig_value;
    logic signed [31:0] central_value;
    logic signed [31:0] variation_value;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        bin_index;
    logic signed [31:0] up_value;
    logic signed [31:0] down_value;
    logic               status;
  } out_item_t;

  // one closed bin handed from the front to the back
  typedef struct packed {
    logic [1:0]         mode;
    logic [10:0]        n;
    logic [63:0]        sum_up;
    logic [63:0]        sum_down;
    logic signed [47:0] lin_sum;
    logic signed [31:0] base;
    logic [15:0]        bin;
  } bin_rec_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_SCALE,
    F_SQUARE,
    F_ACC
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_DIV,
    B_ROOT,
    B_DONE
  } back_state_t;

  // multiply by unsigned Q8.16 scale, round half up, saturate
  function automatic logic signed [31:0] scale_value(input logic signed [31:0] x,
                                                     input logic [23:0] s);
    logic signed [56:0] prod;
    logic signed [57:0] biased;
    logic signed [41:0] shifted;
    prod    = x * $signed({1'b0, s});
    biased  = 58'(prod) + $signed(58'(1) << (FRAC_BITS - 1));
    shifted = 42'(biased >>> FRAC_BITS);
    if (shifted[41:31] == '0 || shifted[41:31] == '1) begin
      return shifted[31:0];
    end
    return shifted[41] ? 32'h8000_0000 : 32'h7fff_ffff;
  endfunction

  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    if (v[33:31] == '0 || v[33:31] == '1) begin
      return v[31:0];
    end
    return v[33] ? 32'h8000_0000 : 32'h7fff_ffff;
  endfunction

  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  // clamp the variation count to 1..MAX_VARIATIONS
  function automatic logic [10:0] clamp_n(input logic [10:0] v);
    if (v == '0) begin
      return 11'd1;
    end
    if (v > 11'(MAX_VARIATIONS)) begin
      return 11'(MAX_VARIATIONS);
    end
    return v;
  endfunction

  function automatic logic [31:0] abs33(input logic signed [32:0] v);
    logic [32:0] m;
    m = v[32] ? 33'(-v) : 33'(v);
    return m[31:0];
  endfunction

endpackage

// File: rtl/pdfue_front.sv
module pdfue_front import pdfue_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  output logic     push,
  output bin_rec_t push_rec,
  input  logic     q_full
);

  front_state_t state, state_next;

  in_item_t           raw;
  cfg_t               cfg_lat;
  logic [10:0]        n_lat;
  logic signed [31:0] x_s, c_s, base_s;
  logic [63:0]        sq_a, sq_b;
  logic [10:0]        item_count;
  logic signed [31:0] pending_minus;
  logic [63:0]        sum_up, sum_down;
  logic signed [47:0] lin_sum;
  logic [15:0]        bin_counter;

  logic               replica, odd, closing, advance;
  logic signed [32:0] d_sym, up_d, dn_d;
  logic signed [31:0] hi_v, lo_v;
  logic [31:0]        op_a, op_b;
  logic               en_a, en_b;
  logic [63:0]        sum_up_next, sum_down_next;
  logic signed [47:0] lin_sum_next;
  logic signed [31:0] pending_minus_next;
  logic signed [48:0] lin_wide;

  assign replica = cfg_lat.envelope_mode[1];
  assign odd     = item_count[0];
  assign closing = ({1'b0, item_count} + 12'd1) >= {1'b0, n_lat};
  assign advance = (state == F_ACC) && (!closing || !q_full);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE:   if (in_valid) state_next = F_SCALE;
      F_SCALE:  state_next = F_SQUARE;
      F_SQUARE: state_next = F_ACC;
      F_ACC:    if (advance) state_next = F_IDLE;
      default:  state_next = F_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_stall = (state != F_IDLE);
    push     = (state == F_ACC) && closing && !q_full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // pick the excursions to square
  always_comb begin
    d_sym = 33'(x_s) - 33'(pending_minus);
    hi_v  = (x_s > pending_minus) ? x_s : pending_minus;
    lo_v  = (x_s < pending_minus) ? x_s : pending_minus;
    up_d  = 33'(hi_v) - 33'(c_s);
    dn_d  = 33'(c_s) - 33'(lo_v);
    if (replica) begin
      op_a = abs33(33'(x_s));
      en_a = 1'b1;
    end else if (cfg_lat.envelope_mode == MODE_SYM) begin
      op_a = abs33(d_sym);
      en_a = 1'b1;
    end else begin
      op_a = abs33(up_d);
      en_a = (up_d > 0);
    end
    op_b = abs33(dn_d);
    en_b = !replica && (cfg_lat.envelope_mode == MODE_ASYM) && (dn_d > 0);
  end

  // accumulate this item into the bin sums
  always_comb begin
    sum_up_next        = sum_up;
    sum_down_next      = sum_down;
    lin_sum_next       = lin_sum;
    pending_minus_next = pending_minus;
    lin_wide           = 49'(lin_sum) + 49'(x_s);
    if (replica) begin
      sum_up_next = sat_add64(sum_up, sq_a);
      priority if (lin_wide[48:47] == 2'b01) begin
        lin_sum_next = 48'h7fff_ffff_ffff;
      end else if (lin_wide[48:47] == 2'b10) begin
        lin_sum_next = 48'h8000_0000_0000;
      end else begin
        lin_sum_next = lin_wide[47:0];
      end
    end else if (!odd) begin
      pending_minus_next = x_s;
    end else begin
      sum_up_next   = sat_add64(sum_up, sq_a);
      sum_down_next = sat_add64(sum_down, sq_b);
    end
  end

  always_comb begin
    push_rec.mode     = cfg_lat.envelope_mode;
    push_rec.n        = n_lat;
    push_rec.sum_up   = sum_up_next;
    push_rec.sum_down = sum_down_next;
    push_rec.lin_sum  = lin_sum_next;
    push_rec.base     = base_s;
    push_rec.bin      = bin_counter;
  end

  // capture, scale and square the item
  always_ff @(posedge clk) begin
    if (state == F_IDLE && in_valid) begin
      raw     <= in_data;
      cfg_lat <= cfg;
      n_lat   <= clamp_n(cfg.num_variations);
    end
    if (state == F_SCALE) begin
      x_s    <= scale_value(raw.variation_value, cfg_lat.scale_cen);
      c_s    <= scale_value(raw.central_value, cfg_lat.scale_cen);
      base_s <= scale_value(raw.orig_value, cfg_lat.scale_orig);
    end
    if (state == F_SQUARE) begin
      sq_a <= en_a ? 64'(op_a) * 64'(op_a) : '0;
      sq_b <= en_b ? 64'(op_b) * 64'(op_b) : '0;
    end
  end

  // bin state: advance or clear on close
  always_ff @(posedge clk) begin
    if (rst) begin
      item_count    <= '0;
      pending_minus <= '0;
      sum_up        <= '0;
      sum_down      <= '0;
      lin_sum       <= '0;
      bin_counter   <= '0;
    end else if (advance) begin
      if (closing) begin
        item_count    <= '0;
        pending_minus <= '0;
        sum_up        <= '0;
        sum_down      <= '0;
        lin_sum       <= '0;
        bin_counter   <= bin_counter + 16'd1;
      end else begin
        item_count    <= item_count + 11'd1;
        pending_minus <= pending_minus_next;
        sum_up        <= sum_up_next;
        sum_down      <= sum_down_next;
        lin_sum       <= lin_sum_next;
      end
    end
  end

endmodule

// File: rtl/pdfue_queue.sv
module pdfue_queue import pdfue_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  bin_rec_t push_rec,
  output logic     full,
  input  logic     pop,
  output logic     not_empty,
  output bin_rec_t head_rec
);

  bin_rec_t          mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head_rec  = mem[rd_ptr];

  // store the closed bin
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_rec;
    end
  end

  // advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> not_empty)
    else $error("queue pop while empty");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> count == $past(count) + QCNT_W'($past(push)) - QCNT_W'($past(pop)))
    else $error("queue count out of step");
`endif

endmodule

// File: rtl/pdfue_back.sv
module pdfue_back import pdfue_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  input  bin_rec_t  head_rec,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  back_state_t state, state_next;

  bin_rec_t           cur;
  logic [47:0]        mag_r;
  logic [STEP_W-1:0]  step;
  logic [SEQ_W-1:0]   cnt;
  logic [74:0]        acc_a;
  logic [95:0]        acc_b;
  logic [19:0]        div_r;
  logic [95:0]        dvd;
  logic [19:0]        rem;
  logic [63:0]        quo;
  logic               ovf;
  logic [63:0]        rv;
  logic [33:0]        rrem;
  logic [31:0]        root;
  logic               phase;
  logic [31:0]        du, dd;
  logic               status_r;

  logic               cur_rep, head_rep, head_few, load_out;
  logic [31:0]        mul_x;
  logic [23:0]        mul_y;
  logic [55:0]        prod;
  logic [20:0]        remw;
  logic               q_bit;
  logic [19:0]        rem_next;
  logic [63:0]        quo_next;
  logic               ovf_next;
  logic [35:0]        rw, trial;
  logic               r_ge;
  logic [31:0]        root_next;
  logic [33:0]        rrem_next;
  logic               mul_last, div_last, root_last;

  assign cur_rep   = cur.mode[1];
  assign head_rep  = head_rec.mode[1];
  assign head_few  = head_rec.n < 11'd2;
  assign mul_last  = (step == STEP_W'(MUL_STEPS - 1));
  assign div_last  = (cnt == SEQ_W'(DIV_STEPS - 1));
  assign root_last = (cnt == SEQ_W'(ROOT_STEPS - 1));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (q_valid) begin
          if (head_rep) begin
            state_next = head_few ? B_DONE : B_MUL;
          end else begin
            state_next = B_ROOT;
          end
        end
      end
      B_MUL:  if (mul_last) state_next = B_DIV;
      B_DIV:  if (div_last) state_next = B_ROOT;
      B_ROOT: begin
        if (root_last && !(cur.mode == MODE_ASYM && !phase)) state_next = B_DONE;
      end
      B_DONE: if (!out_valid || !out_stall) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop      = (state == B_IDLE) && q_valid;
    load_out = (state == B_DONE) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // shared multiplier operands for the variance terms
  always_comb begin
    unique case (step)
      3'd0:    begin mul_x = cur.sum_up[31:0];  mul_y = 24'(cur.n);   end
      3'd1:    begin mul_x = cur.sum_up[63:32]; mul_y = 24'(cur.n);   end
      3'd2:    begin mul_x = 32'(mag_r[23:0]);  mul_y = mag_r[23:0];  end
      3'd3:    begin mul_x = 32'(mag_r[47:24]); mul_y = mag_r[23:0];  end
      3'd4:    begin mul_x = 32'(mag_r[47:24]); mul_y = mag_r[47:24]; end
      default: begin mul_x = '0;                mul_y = '0;           end
    endcase
    prod = 56'(mul_x) * 56'(mul_y);
  end

  // one restoring division step
  always_comb begin
    remw     = {rem, dvd[95]};
    q_bit    = (remw >= {1'b0, div_r});
    rem_next = q_bit ? 20'(remw - {1'b0, div_r}) : remw[19:0];
    quo_next = {quo[62:0], q_bit};
    ovf_next = ovf | quo[63];
  end

  // one square root step
  always_comb begin
    rw        = {rrem, rv[63:62]};
    trial     = {2'b00, root, 2'b01};
    r_ge      = (rw >= trial);
    rrem_next = r_ge ? 34'(rw - trial) : rw[33:0];
    root_next = {root[30:0], r_ge};
  end

  // datapath sequence
  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        if (q_valid) begin
          cur      <= head_rec;
          mag_r    <= head_rec.lin_sum[47] ? 48'(-head_rec.lin_sum) : 48'(head_rec.lin_sum);
          step     <= '0;
          cnt      <= '0;
          phase    <= 1'b0;
          rv       <= head_rec.sum_up;
          rrem     <= '0;
          root     <= '0;
          rem      <= '0;
          quo      <= '0;
          ovf      <= 1'b0;
          du       <= '0;
          dd       <= '0;
          status_r <= head_rep && head_few;
        end
      end
      B_MUL: begin
        step <= step + STEP_W'(1);
        unique case (step)
          3'd0: begin
            acc_a <= 75'(prod);
            div_r <= 20'(22'(cur.n) * 22'(cur.n - 11'd1));
          end
          3'd1: acc_a <= acc_a + (75'(prod) << 32);
          3'd2: acc_b <= 96'(prod);
          3'd3: acc_b <= acc_b + (96'(prod) << 25);
          3'd4: acc_b <= acc_b + (96'(prod) << 48);
          default: dvd <= (96'(acc_a) >= acc_b) ? 96'(acc_a) - acc_b : '0;
        endcase
      end
      B_DIV: begin
        rem <= rem_next;
        quo <= quo_next;
        ovf <= ovf_next;
        dvd <= {dvd[94:0], 1'b0};
        if (div_last) begin
          cnt  <= '0;
          rv   <= ovf_next ? '1 : quo_next;
          rrem <= '0;
          root <= '0;
        end else begin
          cnt <= cnt + SEQ_W'(1);
        end
      end
      B_ROOT: begin
        if (!root_last) begin
          rrem <= rrem_next;
          root <= root_next;
          rv   <= {rv[61:0], 2'b00};
          cnt  <= cnt + SEQ_W'(1);
        end else begin
          cnt <= '0;
          if (cur_rep) begin
            du <= root_next;
            dd <= root_next;
          end else if (cur.mode == MODE_SYM) begin
            du <= root_next >> 1;
            dd <= root_next >> 1;
          end else if (!phase) begin
            du    <= root_next;
            phase <= 1'b1;
            rv    <= cur.sum_down;
            rrem  <= '0;
            root  <= '0;
          end else begin
            dd <= root_next;
          end
        end
      end
      B_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data.bin_index  <= cur.bin;
      out_data.up_value   <= sat34(34'(cur.base) + $signed({2'b00, du}));
      out_data.down_value <= sat34(34'(cur.base) - $signed({2'b00, dd}));
      out_data.status     <= status_r;
    end
  end

`ifndef SYNTH
  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> state != B_IDLE)
    else $error("bin taken but sequencer stayed idle");
  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    load_out |=> out_valid)
    else $error("result load lost");
  a_status_no_delta: assert property (@(posedge clk) disable iff (rst)
    (state == B_DONE && status_r) |-> (du == '0 && dd == '0))
    else $error("flagged bin carries an uncertainty");
`endif

endmodule

// File: rtl/pdf_uncertainty_envelope_top.sv
// Channel  | valid     | stall     | payload
// ---------+-----------+-----------+---------------------------
// input    | in_valid  | in_stall  | in_data  (in_item_t)
// output   | out_valid | out_stall | out_data (out_item_t)
// config   | cfg_we    | -         | cfg_index, cfg_data
//
// Each item steps through the front: capture, scale, square, accumulate.
// A closed bin goes through a 2-deep queue to the back: symmetric runs one root
// pass, asymmetric one per side, replica 6 multiply, 96 division, 32 root steps.
// Reset is synchronous and clears all bin state at once; no clearing pass.
// A stalled output holds its item; the front keeps taking items until a bin
// closes while the queue is full.
module pdf_uncertainty_envelope_top import pdfue_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  cfg_t     cfg;
  logic     push, q_full, pop, q_valid;
  bin_rec_t push_rec, head_rec;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.envelope_mode  <= MODE_SYM;
      cfg.num_variations <= 11'd2;
      cfg.scale_orig     <= 24'h01_0000;
      cfg.scale_cen      <= 24'h01_0000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:       cfg.envelope_mode  <= cfg_data[1:0];
        REG_NUM_VAR:    cfg.num_variations <= cfg_data[10:0];
        REG_SCALE_ORIG: cfg.scale_orig     <= cfg_data;
        REG_SCALE_CEN:  cfg.scale_cen      <= cfg_data;
        default:        cfg.envelope_mode  <= cfg.envelope_mode;
      endcase
    end
  end

  pdfue_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .push     (push),
    .push_rec (push_rec),
    .q_full   (q_full)
  );

  pdfue_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_rec  (push_rec),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_valid),
    .head_rec  (head_rec)
  );

  pdfue_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .head_rec  (head_rec),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
